[src/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants and types for the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int CHAIN_DEPTH = 8;
    localparam int KEY_W       = 31;
    localparam int BKT_W       = $clog2(MAX_BUCKETS);
    localparam int POS_W       = $clog2(CHAIN_DEPTH);
    localparam int LEN_W       = $clog2(CHAIN_DEPTH + 1);
    localparam int CNT_W       = $clog2(MAX_BUCKETS + 1);
    localparam int ADDR_W      = BKT_W + POS_W;
    localparam int MOD_STEPS   = KEY_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_DEL_FAIL  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic [2:0]       status;
        logic [BKT_W-1:0] bucket;
        logic [POS_W-1:0] pos;
    } t_result;

endpackage

[src/cht_front.sv]
// ----------------------------------------------------------------------------
// cht_front
// Accepts operations and reduces the key to its bucket with a restoring
// modulo, one quotient bit per cycle; hands classified jobs to the queue.
// ----------------------------------------------------------------------------
module cht_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [6:0]                 i_cfg_data,
    input  logic                       i_push,
    input  logic [1:0]                 i_opcode,
    input  logic [cht_pkg::KEY_W-1:0]  i_key,
    output logic                       o_full,
    output logic                       o_job_valid,
    output cht_pkg::t_job              o_job,
    input  logic                       i_job_ready
);
    import cht_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cfg;
    logic [CNT_W-1:0] r_div;
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_shf;
    logic [CNT_W:0]   r_rem;
    logic [4:0]       r_cnt;
    logic [CNT_W-1:0] w_div;
    logic [CNT_W:0]   w_trial;

    always_comb begin
        if (r_cfg == '0) begin
            w_div = CNT_W'(1);
        end else if (r_cfg > CNT_W'(MAX_BUCKETS)) begin
            w_div = CNT_W'(MAX_BUCKETS);
        end else begin
            w_div = r_cfg;
        end
    end

    assign w_trial = {r_rem[CNT_W-1:0], r_shf[KEY_W-1]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_push && i_opcode != OP_NONE) n_state = S_MOD;
            S_MOD:   if (r_cnt == 5'(MOD_STEPS - 1)) n_state = S_OUT;
            S_OUT:   if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CNT_W'(MAX_BUCKETS);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_data[CNT_W-1:0];
        end
        if (r_state == S_IDLE && i_push) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_shf <= i_key;
            r_rem <= '0;
            r_cnt <= '0;
            r_div <= w_div;
        end else if (r_state == S_MOD) begin
            r_shf <= {r_shf[KEY_W-2:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= w_trial - {1'b0, r_div};
            end else begin
                r_rem <= w_trial;
            end
        end
    end

    assign o_full        = (r_state != S_IDLE);
    assign o_job_valid   = (r_state == S_OUT);
    assign o_job.opcode  = r_op;
    assign o_job.key     = r_key;
    assign o_job.bucket  = r_rem[BKT_W-1:0];

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> (r_rem < {1'b0, r_div}))
        else $error("remainder out of range");
    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !i_job_ready |=> o_job_valid && $stable(o_job))
        else $error("job changed while stalled");
    a_no_opnone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> o_job.opcode != OP_NONE)
        else $error("unused opcode reached queue");
`endif

endmodule

[src/cht_queue.sv]
// ----------------------------------------------------------------------------
// cht_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module cht_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    input  cht_pkg::t_job i_wr_job,
    output logic          o_wr_ready,
    output logic          o_rd_valid,
    output cht_pkg::t_job o_rd_job,
    input  logic          i_rd_ready
);
    import cht_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_job   = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
        if (w_wr) r_mem[r_wp] <= i_wr_job;
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && !w_rd |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count wrong");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers inconsistent");
`endif

endmodule

[src/cht_back.sv]
// ----------------------------------------------------------------------------
// cht_back
// Executes jobs on the chain memory: walks the chain one entry at a time through a read
// and a compare state, shifts entries on insert and delete; holds one result for the consumer.
// ----------------------------------------------------------------------------
module cht_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  cht_pkg::t_job     i_job,
    output logic              o_job_ready,
    output logic              o_res_valid,
    output cht_pkg::t_result  o_res,
    input  logic              i_res_ready
);
    import cht_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_INS   = 3'd3;
    localparam logic [2:0] S_DRD   = 3'd4;
    localparam logic [2:0] S_DWR   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_LEN   = 3'd7;

    logic [KEY_W-1:0] r_mem [MAX_BUCKETS*CHAIN_DEPTH];
    logic [LEN_W-1:0] r_len [MAX_BUCKETS];

    logic [2:0]             r_state;
    t_job                   r_job;
    logic [LEN_W-1:0]       r_clen;
    logic [LEN_W-1:0]       r_p;
    logic [KEY_W-1:0]       r_rdata;
    logic [ADDR_W-1:0]      w_raddr;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [KEY_W-1:0]       w_wdata;
    logic                   r_res_v;
    t_result                r_res;
    t_result                r_out;
    logic [MAX_BUCKETS-1:0] r_lv;
    logic [LEN_W-1:0]       r_lrd;
    logic [LEN_W-1:0]       w_len_in;

    assign w_len_in = r_lv[r_job.bucket] ? r_lrd : '0;

    // read address: insert reads p-1 on its first cycle, then p-2; others read p
    always_comb begin
        if (r_state == S_INS && r_p == r_clen) begin
            w_raddr = {r_job.bucket, POS_W'(r_p - LEN_W'(1))};
        end else if (r_state == S_INS) begin
            w_raddr = {r_job.bucket, POS_W'(r_p - LEN_W'(2))};
        end else begin
            w_raddr = {r_job.bucket, r_p[POS_W-1:0]};
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_job.bucket, r_p[POS_W-1:0]};
        w_wdata = r_rdata;
        if (r_state == S_INS) begin
            w_we = 1'b1;
            if (r_p == '0) w_wdata = r_job.key;
        end else if (r_state == S_DWR) begin
            w_we    = 1'b1;
            w_waddr = {r_job.bucket, POS_W'(r_p - LEN_W'(1))};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_lrd <= r_len[i_job.bucket];
    end

    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_v;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res_v <= 1'b0;
            r_lv    <= '0;
        end else begin
            if (r_res_v && i_res_ready && r_state != S_DONE) r_res_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_clen <= w_len_in;
                    if (r_job.opcode == OP_INSERT) begin
                        if (w_len_in >= LEN_W'(CHAIN_DEPTH)) begin
                            r_res   <= '{ST_FULL, r_job.bucket, '0};
                            r_state <= S_DONE;
                        end else begin
                            r_p     <= w_len_in;
                            r_state <= S_INS;
                        end
                    end else begin
                        r_p     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_INS: begin
                    // first cycle at p=len reads p-1; write uses previous read
                    if (r_p == r_clen) begin
                        r_p <= r_p;
                        r_clen <= r_clen + LEN_W'(1);
                        if (r_p == '0) begin
                            r_len[r_job.bucket] <= LEN_W'(1);
                            r_lv[r_job.bucket]  <= 1'b1;
                            r_res   <= '{ST_INSERTED, r_job.bucket, '0};
                            r_state <= S_DONE;
                        end
                    end else if (r_p == '0) begin
                        r_len[r_job.bucket] <= r_clen;
                        r_lv[r_job.bucket]  <= 1'b1;
                        r_res   <= '{ST_INSERTED, r_job.bucket, '0};
                        r_state <= S_DONE;
                    end else begin
                        r_p <= r_p - LEN_W'(1);
                    end
                end
                S_RD: begin
                    if (r_p >= r_clen) begin
                        r_res <= '{(r_job.opcode == OP_SEARCH) ? ST_NOT_FOUND
                                   : ST_DEL_FAIL, r_job.bucket, '0};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_rdata == r_job.key) begin
                        if (r_job.opcode == OP_SEARCH) begin
                            r_res   <= '{ST_FOUND, r_job.bucket, r_p[POS_W-1:0]};
                            r_state <= S_DONE;
                        end else begin
                            r_res   <= '{ST_DELETED, r_job.bucket, r_p[POS_W-1:0]};
                            r_len[r_job.bucket] <= r_clen - LEN_W'(1);
                            r_p     <= r_p + LEN_W'(1);
                            r_state <= S_DRD;
                        end
                    end else begin
                        r_p     <= r_p + LEN_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_DRD: begin
                    if (r_p >= r_clen) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DWR;
                    end
                end
                S_DWR: begin
                    r_p     <= r_p + LEN_W'(1);
                    r_state <= S_DRD;
                end
                S_DONE: begin
                    if (!r_res_v || i_res_ready) begin
                        r_out   <= r_res;
                        r_res_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE && r_state != S_LEN |-> r_clen <= LEN_W'(CHAIN_DEPTH))
        else $error("chain length over depth");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_v && !i_res_ready |=> r_res_v && $stable(r_out))
        else $error("result lost while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_res_v && !i_res_ready |=> r_state == S_DONE)
        else $error("result overwritten");
`endif

endmodule

[src/chained_hash_table.sv]
// Path: an accepted operation passes the bucket modulo in the front, the queue,
//   then the chain walk/shift in the back part, which holds one result.
// The front takes a new operation only after handing its last job to the queue
//   (full stays high until then); the back takes one job at a time.
// Reset (synchronous, active low) clears all chain lengths, the queue and
//   sets bucket_count to 64; stored keys are not cleared.
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with bounded separate chaining and a configured modulus.
// ----------------------------------------------------------------------------
module chained_hash_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [6:0]                 i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_opcode,
    input  logic [cht_pkg::KEY_W-1:0]  i_key,
    output logic                       empty,
    input  logic                       pop,
    output logic [2:0]                 o_status,
    output logic [5:0]                 o_bucket_index,
    output logic [2:0]                 o_chain_position
);
    import cht_pkg::*;

    logic    w_fv, w_fr, w_bv, w_br, w_rv;
    t_job    w_fjob, w_bjob;
    t_result w_res;

    cht_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_push(push), .i_opcode, .i_key, .o_full(full),
        .o_job_valid(w_fv), .o_job(w_fjob), .i_job_ready(w_fr)
    );

    cht_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(w_fv), .i_wr_job(w_fjob), .o_wr_ready(w_fr),
        .o_rd_valid(w_bv), .o_rd_job(w_bjob), .i_rd_ready(w_br)
    );

    cht_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_bv), .i_job(w_bjob), .o_job_ready(w_br),
        .o_res_valid(w_rv), .o_res(w_res), .i_res_ready(pop)
    );

    assign empty            = !w_rv;
    assign o_status         = w_res.status;
    assign o_bucket_index   = 6'(w_res.bucket);
    assign o_chain_position = 3'(w_res.pos);

endmodule
